### src/bdq_pkg.sv
`default_nettype none
package bdq_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CMD_W  = 3;
	localparam int unsigned CAP_W  = 5;

	localparam logic [CAP_W-1:0]         CAP_RESET  = 5'd16;
	localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE       = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_PUSH_REAR  = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_REAR   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

endpackage
`default_nettype wire

### src/bdq_if.sv
`default_nettype none
interface bdq_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [bdq_pkg::CMD_W-1:0]             command;
	logic signed [bdq_pkg::DATA_W-1:0]     value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface bdq_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  ok;
	logic signed [bdq_pkg::DATA_W-1:0]     front_value;
	logic signed [bdq_pkg::DATA_W-1:0]     rear_value;
	logic                                  is_empty;
	logic                                  is_full;

	modport source (output valid, output ok, output front_value, output rear_value,
		output is_empty, output is_full, input ready);
	modport sink   (input valid, input ok, input front_value, input rear_value,
		input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

### src/bounded_double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words held in a ring memory.
// Request channel (req): command and value; accepted when valid and ready are high.
// Commands insert at the front or rear, delete at the front or rear, or do nothing.
// Response channel (rsp): one response per request with ok, the front and rear
// words after the command (-1 when empty), and the empty and full flags.
// cfg_we/cfg_wdata write the capacity limit; values above DEPTH act as DEPTH.
// A request is taken only in the idle state, so a new request waits until the
// last one is loaded. The accepting cycle updates head, count and the written
// entry, the read state does the two-port memory read of front and rear, and
// the load state loads the response register, which then holds the response.
// The response register lets the next request be accepted and processed while
// a response waits; a stalled receiver holds the block in its load state until
// the response register frees.
// Reset: the queue is empty, capacity limit 16, no response pending.
// The memory contents are not cleared; only written entries are ever read.
`default_nettype none
module bounded_double_ended_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	bdq_req_if.sink                           req,
	bdq_rsp_if.source                         rsp,
	input  wire logic                         cfg_we,
	input  wire logic [bdq_pkg::CAP_W-1:0]    cfg_wdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned MW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;

	bdq_pkg::state_t                  state_q, state_d;
	logic [AW-1:0]                    head_q;
	logic [CW-1:0]                    count_q;
	logic [bdq_pkg::CAP_W-1:0]        cap_q;
	logic                             ok_q;

	logic signed [bdq_pkg::DATA_W-1:0] entry_mem_q [DEPTH];
	logic signed [bdq_pkg::DATA_W-1:0] front_s2, rear_s2;

	logic                             rsp_valid_q;
	logic                             rsp_ok_q, rsp_empty_q, rsp_full_q;
	logic signed [bdq_pkg::DATA_W-1:0] rsp_front_q, rsp_rear_q;

	logic                             accept, rd_en, load;
	logic                             wr_en;
	logic [AW-1:0]                    wr_addr;
	logic [AW-1:0]                    head_d;
	logic [CW-1:0]                    count_d;
	logic                             ok_d;
	logic [AW-1:0]                    head_dec, head_inc, tail_addr, rear_addr;
	logic [SW-1:0]                    tail_sum, rear_sum;
	logic [MW-1:0]                    cap_eff;
	logic                             is_full, is_empty;

	assign accept = req.valid && req.ready;

	always_comb begin
		cap_eff  = (MW'(cap_q) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(cap_q);
		is_empty = (count_q == '0);
		is_full  = (MW'(count_q) >= cap_eff);
		head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
		head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
		tail_sum = SW'(head_q) + SW'(count_q);
		tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
		rear_sum = tail_sum - SW'(1);
		rear_addr = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);
	end

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		ok_d    = 1'b1;
		wr_en   = 1'b0;
		wr_addr = tail_addr;
		case (req.command)
			bdq_pkg::CMD_NONE: begin
			end
			bdq_pkg::CMD_PUSH_FRONT: begin
				if (is_full) begin
					ok_d = 1'b0;
				end else begin
					head_d  = head_dec;
					count_d = count_q + CW'(1);
					wr_en   = 1'b1;
					wr_addr = head_dec;
				end
			end
			bdq_pkg::CMD_PUSH_REAR: begin
				if (is_full) begin
					ok_d = 1'b0;
				end else begin
					count_d = count_q + CW'(1);
					wr_en   = 1'b1;
				end
			end
			bdq_pkg::CMD_POP_FRONT: begin
				if (is_empty) begin
					ok_d = 1'b0;
				end else begin
					head_d  = head_inc;
					count_d = count_q - CW'(1);
				end
			end
			bdq_pkg::CMD_POP_REAR: begin
				if (is_empty) begin
					ok_d = 1'b0;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (accept) state_d = bdq_pkg::ST_READ;
			end
			bdq_pkg::ST_READ: begin
				state_d = bdq_pkg::ST_LOAD;
			end
			bdq_pkg::ST_LOAD: begin
				if (load) state_d = bdq_pkg::ST_IDLE;
			end
			default: begin
				state_d = bdq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		load      = 1'b0;
		case (state_q)
			bdq_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			bdq_pkg::ST_READ: begin
				rd_en = 1'b1;
			end
			bdq_pkg::ST_LOAD: begin
				load = !rsp_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdq_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			cap_q       <= bdq_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cap_q <= cfg_wdata;
			if (accept) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) ok_q <= ok_d;
		if (accept && wr_en) entry_mem_q[wr_addr] <= req.value;
		if (rd_en) begin
			front_s2 <= entry_mem_q[head_q];
			rear_s2  <= entry_mem_q[rear_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_ok_q    <= ok_q;
			rsp_empty_q <= is_empty;
			rsp_full_q  <= is_full;
			rsp_front_q <= is_empty ? bdq_pkg::EMPTY_WORD : front_s2;
			rsp_rear_q  <= is_empty ? bdq_pkg::EMPTY_WORD : rear_s2;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.front_value = rsp_front_q;
	assign rsp.rear_value  = rsp_rear_q;
	assign rsp.is_empty    = rsp_empty_q;
	assign rsp.is_full     = rsp_full_q;

endmodule
`default_nettype wire

### src/bdq_checker.sv
`default_nettype none
module bdq_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               req_valid,
	input wire logic                               req_ready,
	input wire logic                               rsp_valid,
	input wire logic                               rsp_ready,
	input wire logic signed [bdq_pkg::DATA_W-1:0]  rsp_front_value,
	input wire logic signed [bdq_pkg::DATA_W-1:0]  rsp_rear_value,
	input wire logic                               rsp_is_empty
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_empty |->
			rsp_front_value == bdq_pkg::EMPTY_WORD && rsp_rear_value == bdq_pkg::EMPTY_WORD)
		else $error("empty response carries entry words");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while one is in flight");

	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without a request in flight");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_front_value (rsp.front_value),
	.rsp_rear_value  (rsp.rear_value),
	.rsp_is_empty    (rsp.is_empty)
);
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
	import bdq_pkg::*;

	localparam int unsigned RING_DEPTH = 16;
	localparam int unsigned GAP_MAX = 14;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS = 68;
	localparam int unsigned REPORT_LIMIT = 10;

	localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;
	localparam logic signed [DATA_W-1:0] WORD_TAG = 32'sh12345678;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic                     is_empty;
		logic                     is_full;
	} deque_view_t;

	typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [CAP_W-1:0]         cap;
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] value;
		logic                     known;
		deque_view_t              view;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_double_ended_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	logic signed [DATA_W-1:0] shadow_ring [RING_DEPTH];
	logic [3:0]               shadow_head;
	int unsigned              shadow_count;
	int unsigned              shadow_cap;

	deque_view_t expected_views [$];
	int unsigned fault_count = 0;

	logic        row_known = 1'b0;
	deque_view_t row_view = '0;
	logic        send_gaps_on = 1'b1;
	logic        recv_gaps_on = 1'b1;
	logic        hold_off_pending = 1'b0;

	stim_row_t directed_rows [28] = '{
		'{ROW_REQ, 5'd0, CMD_NONE, 32'sd0, 1'b1, '{1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0}},
		'{ROW_REQ, 5'd0, CMD_POP_FRONT, 32'sd0, 1'b1, '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0}},
		'{ROW_REQ, 5'd0, CMD_POP_REAR, 32'sd0, 1'b1, '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0}},
		'{ROW_REQ, 5'd0, CMD_RSVD5, 32'sd0, 1'b1, '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0}},
		'{ROW_REQ, 5'd0, CMD_PUSH_REAR, WORD_MAX, 1'b1, '{1'b1, WORD_MAX, WORD_MAX, 1'b0, 1'b0}},
		'{ROW_REQ, 5'd0, CMD_PUSH_FRONT, WORD_MIN, 1'b1, '{1'b1, WORD_MIN, WORD_MAX, 1'b0, 1'b0}},
		'{ROW_REQ, 5'd0, CMD_RSVD7, -32'sd1, 1'b1, '{1'b0, WORD_MIN, WORD_MAX, 1'b0, 1'b0}},
		'{ROW_REQ, 5'd0, CMD_RSVD6, 32'sd0, 1'b1, '{1'b0, WORD_MIN, WORD_MAX, 1'b0, 1'b0}},
		'{ROW_REQ, 5'd0, CMD_PUSH_REAR, 32'sh5a5a5a5a, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_POP_FRONT, 32'sd0, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_POP_REAR, 32'sd0, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_POP_REAR, 32'sd0, 1'b0, '0},
		'{ROW_CAP, 5'd1, CMD_NONE, 32'sd0, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_PUSH_FRONT, WORD_TAG, 1'b1, '{1'b1, WORD_TAG, WORD_TAG, 1'b0, 1'b1}},
		'{ROW_REQ, 5'd0, CMD_PUSH_REAR, 32'sd1, 1'b1, '{1'b0, WORD_TAG, WORD_TAG, 1'b0, 1'b1}},
		'{ROW_CAP, 5'd0, CMD_NONE, 32'sd0, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_PUSH_REAR, 32'sd2, 1'b1, '{1'b0, WORD_TAG, WORD_TAG, 1'b0, 1'b1}},
		'{ROW_REQ, 5'd0, CMD_POP_FRONT, 32'sd0, 1'b1, '{1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b1}},
		'{ROW_REQ, 5'd0, CMD_PUSH_FRONT, 32'sd3, 1'b1, '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b1}},
		'{ROW_CAP, 5'd31, CMD_NONE, 32'sd0, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_PUSH_REAR, 32'sha5a5a5a5, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_PUSH_FRONT, 32'sh0f0f0f0f, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_PUSH_REAR, 32'shf0f0f0f0, 1'b0, '0},
		'{ROW_CAP, 5'd2, CMD_NONE, 32'sd0, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_PUSH_REAR, 32'sd4, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_POP_FRONT, 32'sd0, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_POP_REAR, 32'sd0, 1'b0, '0},
		'{ROW_REQ, 5'd0, CMD_POP_REAR, 32'sd0, 1'b0, '0}
	};

	int unsigned phase_caps [15] = '{16, 1, 0, 16, 31, 3, 16, 2, 17, 8, 16, 0, 15, 1, 31};

	task automatic deque_apply(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] word,
		output deque_view_t view);
		int unsigned limit;
		logic        full;
		logic [3:0]  slot;
		limit = (shadow_cap > RING_DEPTH) ? RING_DEPTH : shadow_cap;
		full = shadow_count >= limit;
		view.ok = 1'b1;
		case (cmd)
			CMD_NONE: ;
			CMD_PUSH_FRONT: begin
				if (full) begin
					view.ok = 1'b0;
				end else begin
					shadow_head = shadow_head - 4'd1;
					shadow_ring[shadow_head] = word;
					shadow_count++;
				end
			end
			CMD_PUSH_REAR: begin
				if (full) begin
					view.ok = 1'b0;
				end else begin
					slot = shadow_head + 4'(shadow_count);
					shadow_ring[slot] = word;
					shadow_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (shadow_count == 0) begin
					view.ok = 1'b0;
				end else begin
					shadow_head = shadow_head + 4'd1;
					shadow_count--;
				end
			end
			CMD_POP_REAR: begin
				if (shadow_count == 0) begin
					view.ok = 1'b0;
				end else begin
					shadow_count--;
				end
			end
			default: view.ok = 1'b0;
		endcase
		view.is_empty = shadow_count == 0;
		view.is_full = shadow_count >= limit;
		if (view.is_empty) begin
			view.front_value = EMPTY_WORD;
			view.rear_value = EMPTY_WORD;
		end else begin
			slot = shadow_head + 4'(shadow_count - 1);
			view.front_value = shadow_ring[shadow_head];
			view.rear_value = shadow_ring[slot];
		end
	endtask

	always @(posedge clk) begin : observe
		deque_view_t got;
		deque_view_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.ok, rsp_ch.front_value, rsp_ch.rear_value, rsp_ch.is_empty,
					rsp_ch.is_full};
				if (expected_views.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("unexpected response: ok %0b front %0d rear %0d",
							got.ok, got.front_value, got.rear_value,
							" empty %0b full %0b", got.is_empty, got.is_full);
				end else begin
					want = expected_views.pop_front();
					if (got !== want) begin
						fault_count++;
						if (fault_count <= REPORT_LIMIT)
							$display("mismatch (exp/act): ok %0b/%0b front %0d/%0d",
								want.ok, got.ok, want.front_value, got.front_value,
								" rear %0d/%0d empty %0b/%0b full %0b/%0b",
								want.rear_value, got.rear_value, want.is_empty, got.is_empty,
								want.is_full, got.is_full);
					end
				end
			end
			if (cfg_we)
				shadow_cap = 32'(cfg_wdata);
			if (req_ch.valid && req_ch.ready) begin
				deque_apply(req_ch.command, req_ch.value, want);
				if (row_known)
					want = row_view;
				expected_views.push_back(want);
			end
		end
	end

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] word,
		input logic known, input deque_view_t view);
		int unsigned gap;
		gap = send_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.command = cmd;
		req_ch.value = word;
		row_known = known;
		row_view = view;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain_requests();
		req_ch.valid = 1'b0;
		while (expected_views.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		drain_requests();
		cfg_we = 1'b1;
		cfg_wdata = cap;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin : rsp_side
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				rsp_ch.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			stall = recv_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
			if (stall != 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	initial begin : stimulus
		int unsigned              r;
		int unsigned              push_pct;
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] word;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_NONE;
		req_ch.value = '0;
		shadow_head = '0;
		shadow_count = 0;
		shadow_cap = 32'(CAP_RESET);
		foreach (shadow_ring[i])
			shadow_ring[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CAP)
				write_capacity(directed_rows[i].cap);
			else
				send_request(directed_rows[i].cmd, directed_rows[i].value,
					directed_rows[i].known, directed_rows[i].view);
		end

		push_pct = 50;
		foreach (phase_caps[p]) begin
			write_capacity(CAP_W'(phase_caps[p]));
			send_gaps_on = $urandom_range(0, 3) != 0;
			recv_gaps_on = $urandom_range(0, 3) != 0;
			if (p == 3) begin
				send_gaps_on = 1'b0;
				hold_off_pending = 1'b1;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 17 == 0) begin
					case ($urandom_range(0, 2))
						0: push_pct = 80;
						1: push_pct = 20;
						default: push_pct = 50;
					endcase
				end
				r = $urandom_range(0, 99);
				if (r < 4)
					cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
				else if (r < 8)
					cmd = CMD_NONE;
				else if ($urandom_range(0, 99) < push_pct)
					cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
				else
					cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
				case ($urandom_range(0, 15))
					0: word = WORD_MAX;
					1: word = WORD_MIN;
					2: word = '0;
					3: word = -32'sd1;
					default: word = $urandom;
				endcase
				send_request(cmd, word, 1'b0, '0);
			end
		end

		drain_requests();
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
